/* rtl/vhmt_pkg.sv */
// Shared types and constants for the virtual handle map table.
// No dependencies; used by vhmt_cell and virtual_handle_map_table.
package vhmt_pkg;

    localparam int HANDLE_W = 32;
    localparam int ACTION_W = 2;
    localparam int STATUS_W = 2;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_NEW = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_MAP = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_DEL = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

    // lookup token that walks the cell row
    typedef struct packed {
        logic                valid;
        logic                del;
        logic                found;
        logic [HANDLE_W-1:0] key;
        logic [HANDLE_W-1:0] data;
    } token_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_WALK = 3'b010,
        ST_DONE = 3'b100
    } state_t;

endpackage

/* rtl/vhmt_cell.sv */
// One table slot: holds a client/real handle pair and passes the lookup token on.
// Depends on vhmt_pkg.
module vhmt_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 5
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [CNT_W-1:0]              cnt,
    input  vhmt_pkg::token_t              tok_in,
    output vhmt_pkg::token_t              tok_out,
    input  logic                          wr_en,
    input  logic [vhmt_pkg::HANDLE_W-1:0] wr_client,
    input  logic [vhmt_pkg::HANDLE_W-1:0] wr_real,
    input  logic                          pull_in,
    input  logic [vhmt_pkg::HANDLE_W-1:0] nbr_client,
    input  logic [vhmt_pkg::HANDLE_W-1:0] nbr_real,
    output logic                          pull_out,
    output logic [vhmt_pkg::HANDLE_W-1:0] client_out,
    output logic [vhmt_pkg::HANDLE_W-1:0] real_out
);

    logic [vhmt_pkg::HANDLE_W-1:0] client_reg, client_next;
    logic [vhmt_pkg::HANDLE_W-1:0] real_reg, real_next;
    vhmt_pkg::token_t              tok_reg, tok_next;
    logic                          hit;

    // first valid match along the row
    assign hit = tok_in.valid && !tok_in.found && (cnt > CNT_W'(IDX))
                 && (client_reg == tok_in.key);

    // a delete already matched upstream: the previous slot takes this entry
    assign pull_out = tok_in.valid && tok_in.del && tok_in.found;

    always_comb begin
        tok_next       = tok_in;
        tok_next.found = tok_in.found | hit;
        if (hit) begin
            tok_next.data = real_reg;
        end
    end

    // entry update: append write or shift down from the neighbor
    always_comb begin
        client_next = client_reg;
        real_next   = real_reg;
        priority if (wr_en) begin
            client_next = wr_client;
            real_next   = wr_real;
        end else if (pull_in) begin
            client_next = nbr_client;
            real_next   = nbr_real;
        end
    end

    always_ff @(posedge aclk) begin
        client_reg <= client_next;
        real_reg   <= real_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg <= '0;
        end else begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out    = tok_reg;
    assign client_out = client_reg;
    assign real_out   = real_reg;

endmodule

/* rtl/virtual_handle_map_table.sv */
// Virtual handle map table: ordered client-to-real handle map in a row of cells.
// Sequence: new and unused actions pass from idle through done to the output register;
// map and delete walk the token along the row, one cell per cycle, then go to done.
// Throughput: one item at a time, a new beat taken only in the idle state;
// a result stalled by m_tready holds the next item in the done state.
// Reset (aresetn low, synchronous): table empty, next client handle 1, no beat pending.
// Depends on vhmt_pkg and vhmt_cell.
module virtual_handle_map_table #(
    parameter int ENTRIES = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [1:0] action, [33:2] handle, [39:34] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // [31:0] handle_out, [33:32] status, [39:34] zero
);

    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int HW    = vhmt_pkg::HANDLE_W;

    vhmt_pkg::state_t              state_reg, state_next;
    logic [CNT_W-1:0]              count_reg, count_next;
    logic [HW-1:0]                 next_id_reg, next_id_next;
    vhmt_pkg::token_t              tok0_reg, tok0_next;
    logic [HW-1:0]                 res_handle_reg, res_handle_next;
    logic [vhmt_pkg::STATUS_W-1:0] res_status_reg, res_status_next;
    logic                          m_tvalid_reg, m_tvalid_next;
    logic [39:0]                   m_tdata_reg, m_tdata_next;

    logic [vhmt_pkg::ACTION_W-1:0] in_action;
    logic [HW-1:0]                 in_handle;
    logic                          accept;
    logic                          full;
    logic                          wr_en;

    vhmt_pkg::token_t tok    [ENTRIES+1];
    logic [HW-1:0]    client [ENTRIES];
    logic [HW-1:0]    realh  [ENTRIES];
    logic             pull   [ENTRIES];

    assign in_action = s_tdata[1:0];
    assign in_handle = s_tdata[33:2];
    assign s_tready  = (state_reg == vhmt_pkg::ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign full      = (count_reg == CNT_W'(ENTRIES));
    assign wr_en     = accept && (in_action == vhmt_pkg::ACT_NEW) && !full;

    assign tok[0] = tok0_reg;

    // row of table cells
    for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
        logic          pull_in;
        logic [HW-1:0] nbr_client;
        logic [HW-1:0] nbr_real;

        if (i < ENTRIES - 1) begin : g_mid
            assign pull_in    = pull[i+1];
            assign nbr_client = client[i+1];
            assign nbr_real   = realh[i+1];
        end else begin : g_last
            assign pull_in    = 1'b0;
            assign nbr_client = '0;
            assign nbr_real   = '0;
        end

        vhmt_cell #(
            .IDX   (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .cnt        (count_reg),
            .tok_in     (tok[i]),
            .tok_out    (tok[i+1]),
            .wr_en      (wr_en && (count_reg == CNT_W'(i))),
            .wr_client  (next_id_reg),
            .wr_real    (in_handle),
            .pull_in    (pull_in),
            .nbr_client (nbr_client),
            .nbr_real   (nbr_real),
            .pull_out   (pull[i]),
            .client_out (client[i]),
            .real_out   (realh[i])
        );
    end

    // control sequencer
    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        next_id_next    = next_id_reg;
        tok0_next       = '0;
        res_handle_next = res_handle_reg;
        res_status_next = res_status_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;

        unique case (state_reg)
            vhmt_pkg::ST_IDLE: begin
                if (accept) begin
                    res_handle_next = '0;
                    res_status_next = vhmt_pkg::ST_OK;
                    unique case (in_action)
                        vhmt_pkg::ACT_NEW: begin
                            if (full) begin
                                res_status_next = vhmt_pkg::ST_FULL;
                            end else begin
                                res_handle_next = next_id_reg;
                                next_id_next    = next_id_reg + HW'(1);
                                count_next      = count_reg + CNT_W'(1);
                            end
                            state_next = vhmt_pkg::ST_DONE;
                        end
                        vhmt_pkg::ACT_MAP, vhmt_pkg::ACT_DEL: begin
                            tok0_next.valid = 1'b1;
                            tok0_next.del   = (in_action == vhmt_pkg::ACT_DEL);
                            tok0_next.key   = in_handle;
                            state_next      = vhmt_pkg::ST_WALK;
                        end
                        default: begin
                            state_next = vhmt_pkg::ST_DONE;
                        end
                    endcase
                end
            end
            vhmt_pkg::ST_WALK: begin
                // token leaves the last cell
                if (tok[ENTRIES].valid) begin
                    res_status_next = tok[ENTRIES].found ? vhmt_pkg::ST_OK
                                                         : vhmt_pkg::ST_NOT_FOUND;
                    res_handle_next = (tok[ENTRIES].found && !tok[ENTRIES].del)
                                      ? tok[ENTRIES].data : '0;
                    if (tok[ENTRIES].del && tok[ENTRIES].found) begin
                        count_next = count_reg - CNT_W'(1);
                    end
                    state_next = vhmt_pkg::ST_DONE;
                end
            end
            vhmt_pkg::ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {6'b0, res_status_reg, res_handle_reg};
                    state_next    = vhmt_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = vhmt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= vhmt_pkg::ST_IDLE;
            count_reg    <= '0;
            next_id_reg  <= HW'(1);
            tok0_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            next_id_reg  <= next_id_next;
            tok0_reg     <= tok0_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_handle_reg <= res_handle_next;
        res_status_reg <= res_status_next;
        m_tdata_reg    <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
